FILE: sv/assert_macros.svh
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define TBI_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define TBI_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/tbi_pkg.sv
`default_nettype none

package tbi_pkg;

    localparam int MASS_W            = 22;
    localparam int MOMENTUM_BITS_DEF = 25;

    localparam logic [MASS_W-1:0] PROTON_MASS_RST = 22'd938272;
    localparam logic [MASS_W-1:0] LAMBDA_MASS_RST = 22'd1115683;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROTON_MASS = 8'd0,
        REG_LAMBDA_MASS = 8'd1
    } cfg_reg_t;

    localparam int Q3_W = 26;
    localparam logic [Q3_W-1:0] Q3_MAX = '1;

    // Energies carry this many fraction bits squared (E * 2^16 -> E^2 * 2^32).
    localparam int FRAC_SH = 32;

    // Pair arithmetic, fixed by the clamp limits.
    localparam int T_W    = 57;          // clamped t, signed, |t| <= 2^55
    localparam int U_W    = T_W + 1;     // u and s, signed
    localparam int MAG_W  = 56;          // |t| and |u|
    localparam int HALF_W = MAG_W / 2;
    localparam int N_W    = 2 * MAG_W;   // numerator |t|*|u|
    localparam int D_W    = 57;          // positive denominator
    localparam int QUO_W  = 61;          // quotient kept up to the term limit
    localparam int SUM_W  = 63;          // sum of three terms, signed
    localparam int RT_W   = 32;          // final root width
    localparam int RAD_W  = 2 * RT_W;

    localparam logic signed [T_W-1:0] T_LIMIT    = {2'b01, 55'd0};
    localparam logic [QUO_W-1:0]      TERM_LIMIT = {1'b1, 60'd0};

endpackage

`default_nettype wire

FILE: sv/tbi_if.sv
`default_nettype none

// Triplet request channel.
interface tbi_in_if #(parameter int MOMENTUM_BITS = tbi_pkg::MOMENTUM_BITS_DEF);
    logic                            valid;
    logic                            ready;
    logic signed [MOMENTUM_BITS-1:0] lambda_px;
    logic signed [MOMENTUM_BITS-1:0] lambda_py;
    logic signed [MOMENTUM_BITS-1:0] lambda_pz;
    logic signed [MOMENTUM_BITS-1:0] first_proton_px;
    logic signed [MOMENTUM_BITS-1:0] first_proton_py;
    logic signed [MOMENTUM_BITS-1:0] first_proton_pz;
    logic signed [MOMENTUM_BITS-1:0] second_proton_px;
    logic signed [MOMENTUM_BITS-1:0] second_proton_py;
    logic signed [MOMENTUM_BITS-1:0] second_proton_pz;

    modport source (
        output valid, lambda_px, lambda_py, lambda_pz,
               first_proton_px, first_proton_py, first_proton_pz,
               second_proton_px, second_proton_py, second_proton_pz,
        input  ready
    );
    modport sink (
        input  valid, lambda_px, lambda_py, lambda_pz,
               first_proton_px, first_proton_py, first_proton_pz,
               second_proton_px, second_proton_py, second_proton_pz,
        output ready
    );
endinterface

// Result request channel.
interface tbi_out_if;
    import tbi_pkg::*;
    logic            valid;
    logic            ready;
    logic [Q3_W-1:0] q3_value;
    logic            negative_radicand;

    modport source (output valid, q3_value, negative_radicand, input ready);
    modport sink   (input  valid, q3_value, negative_radicand, output ready);
endinterface

// Register write channel.
interface tbi_cfg_if;
    import tbi_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input  valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: sv/three_body_invariant_q3_top.sv
// Channel   Role   Payload
// triplet   sink   three momenta each of lambda, first and second proton
// result    source q3_value, negative_radicand
// cfg       sink   index, data (register write, always ready)
//
// One triplet enters per cycle while the pipeline is not frozen.
// NE is the energy root width, 42 at 25-bit momenta.
// The latency is set by the bit-per-stage energy root, pair divider and final root.
// rst_n clears the mass registers to their defaults and empties the pipeline.
// The whole pipeline freezes only while two results sit unread in the output buffer.
`default_nettype none

module three_body_invariant_q3_top #(
    parameter int MOMENTUM_BITS = tbi_pkg::MOMENTUM_BITS_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    tbi_in_if.sink     triplet,
    tbi_out_if.source  result,
    tbi_cfg_if.sink    cfg
);
    import tbi_pkg::*;

    localparam int M    = MOMENTUM_BITS;
    localparam int SQ_W = 2 * M;
    localparam int BIG  = (2 * M > 2 * MASS_W) ? 2 * M : 2 * MASS_W;
    localparam int XW   = BIG + 2;                 // p.p + m*m, even width
    localparam int NE   = (XW + FRAC_SH) / 2;      // energy root width
    localparam int EH   = (NE + 1) / 2;            // energy multiplier half
    localparam int PW   = 4 * EH;                  // Ea*Eb width
    localparam int AW   = BIG + 3;                 // pa.pb + ma*mb, signed
    localparam int TRB  = ((PW - FRAC_SH > AW) ? PW - FRAC_SH : AW) + 2;
    // wide enough to also hold the clamp limit with its sign
    localparam int TRW  = (TRB > T_W) ? TRB : T_W + 1;
    localparam int ND   = N_W;                     // divider steps
    localparam int LAT  = NE + ND + RT_W + 10;
    localparam int MP_W = 2 * MASS_W;
    localparam int MS_W = MASS_W + 1;

    // ------------------------------------------------------------------
    // Masses, derived products: user keeps static while items in flight; not enforced
    // ------------------------------------------------------------------
    logic [MASS_W-1:0] pm_reg;
    logic [MASS_W-1:0] lm_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pm_reg <= PROTON_MASS_RST;
            lm_reg <= LAMBDA_MASS_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_PROTON_MASS: pm_reg <= cfg.data[MASS_W-1:0];
                REG_LAMBDA_MASS: lm_reg <= cfg.data[MASS_W-1:0];
                default:         ;
            endcase
        end
    end

    logic [MP_W-1:0]   mm_ll_reg, mm_pp_reg, mm_lp_reg;
    logic [2*MS_W-1:0] ms_lp_reg, ms_pp_reg;

    always_ff @(posedge clk)
    begin
        mm_ll_reg <= lm_reg * lm_reg;
        mm_pp_reg <= pm_reg * pm_reg;
        mm_lp_reg <= lm_reg * pm_reg;
        ms_lp_reg <= (MS_W'(lm_reg) + MS_W'(pm_reg)) * (MS_W'(lm_reg) + MS_W'(pm_reg));
        ms_pp_reg <= {pm_reg, 1'b0} * {pm_reg, 1'b0};
    end

    // Per particle m^2, per pair ma*mb and (ma+mb)^2.
    // Pairs: 0 = lambda/p1, 1 = p1/p2, 2 = p2/lambda.
    logic [MP_W-1:0]   msq   [3];
    logic [MP_W-1:0]   mprod [3];
    logic [2*MS_W-1:0] msum  [3];

    always_comb
    begin
        msq[0]   = mm_ll_reg;
        msq[1]   = mm_pp_reg;
        msq[2]   = mm_pp_reg;
        mprod[0] = mm_lp_reg;
        mprod[1] = mm_pp_reg;
        mprod[2] = mm_lp_reg;
        msum[0]  = ms_lp_reg;
        msum[1]  = ms_pp_reg;
        msum[2]  = ms_lp_reg;
    end

    // ------------------------------------------------------------------
    // Flow control: global enable, two-entry output buffer
    // ------------------------------------------------------------------
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    logic       pop, push, en;
    logic [LAT-1:0] v_reg;

    assign result.valid  = (cnt_reg != 2'd0);
    assign pop           = result.valid && result.ready;
    assign en            = (cnt_reg != 2'd2) || pop;
    assign push          = en && v_reg[LAT-1];
    assign triplet.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[LAT-2:0], triplet.valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture momenta [particle][axis]
    // ------------------------------------------------------------------
    logic signed [M-1:0] mom_reg [3][3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mom_reg[0][0] <= M'(triplet.lambda_px);
            mom_reg[0][1] <= M'(triplet.lambda_py);
            mom_reg[0][2] <= M'(triplet.lambda_pz);
            mom_reg[1][0] <= M'(triplet.first_proton_px);
            mom_reg[1][1] <= M'(triplet.first_proton_py);
            mom_reg[1][2] <= M'(triplet.first_proton_pz);
            mom_reg[2][0] <= M'(triplet.second_proton_px);
            mom_reg[2][1] <= M'(triplet.second_proton_py);
            mom_reg[2][2] <= M'(triplet.second_proton_pz);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squares and pair dot-product terms
    // ------------------------------------------------------------------
    logic signed [SQ_W-1:0] sq_reg [3][3];
    logic signed [SQ_W-1:0] dp_reg [3][3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sq_reg[k][i] <= mom_reg[k][i] * mom_reg[k][i];
                    dp_reg[k][i] <= mom_reg[k][i] * mom_reg[(k == 2) ? 0 : k + 1][i];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 3 and energy root: E = floor(sqrt((p.p + m^2) * 2^32)),
    // two radicand bits per stage
    // ------------------------------------------------------------------
    logic [XW-1:0]          ex_reg    [3][NE+1];
    logic [NE:0]            erem_reg  [3][NE+1];
    logic [NE-1:0]          eroot_reg [3][NE+1];
    logic signed [AW-1:0]   acc_reg   [3][NE+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ex_reg[k][0]    <= XW'($unsigned(sq_reg[k][0])) + XW'($unsigned(sq_reg[k][1]))
                                 + XW'($unsigned(sq_reg[k][2])) + XW'(msq[k]);
                erem_reg[k][0]  <= '0;
                eroot_reg[k][0] <= '0;
                acc_reg[k][0]   <= AW'(dp_reg[k][0]) + AW'(dp_reg[k][1])
                                 + AW'(dp_reg[k][2]) + AW'(mprod[k]);
            end
        end
    end

    for (genvar j = 0; j < NE; j++)
    begin : g_esq
        logic [NE+2:0] r4 [3];
        logic [NE+2:0] tr [3];
        logic [NE+2:0] df [3];

        always_comb
        begin
            for (int k = 0; k < 3; k++)
            begin
                r4[k] = {erem_reg[k][j], ex_reg[k][j][XW-1 -: 2]};
                tr[k] = {1'b0, eroot_reg[k][j], 2'b01};
                df[k] = r4[k] - tr[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    ex_reg[k][j+1]    <= {ex_reg[k][j][XW-3:0], 2'b00};
                    erem_reg[k][j+1]  <= (r4[k] >= tr[k]) ? df[k][NE:0] : r4[k][NE:0];
                    eroot_reg[k][j+1] <= {eroot_reg[k][j][NE-2:0], (r4[k] >= tr[k])};
                    acc_reg[k][j+1]   <= acc_reg[k][j];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Ea*Eb as four half-width partial products, then summed
    // ------------------------------------------------------------------
    logic [2*EH-1:0]      ea [3];
    logic [2*EH-1:0]      eb [3];
    logic [2*EH-1:0]      ep_reg    [3][4];
    logic signed [AW-1:0] acc_e_reg [3];
    logic [PW-1:0]        eprod_reg [3];
    logic signed [AW-1:0] acc_f_reg [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ea[k] = (2*EH)'(eroot_reg[k][NE]);
            eb[k] = (2*EH)'(eroot_reg[(k == 2) ? 0 : k + 1][NE]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ep_reg[k][0] <= ea[k][EH-1:0]    * eb[k][EH-1:0];
                ep_reg[k][1] <= ea[k][EH-1:0]    * eb[k][2*EH-1:EH];
                ep_reg[k][2] <= ea[k][2*EH-1:EH] * eb[k][EH-1:0];
                ep_reg[k][3] <= ea[k][2*EH-1:EH] * eb[k][2*EH-1:EH];
                acc_e_reg[k] <= acc_reg[k][NE];
                eprod_reg[k] <= (PW'(ep_reg[k][3]) << (2*EH))
                              + ((PW'(ep_reg[k][1]) + PW'(ep_reg[k][2])) << EH)
                              + PW'(ep_reg[k][0]);
                acc_f_reg[k] <= acc_e_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // t = floor(Ea*Eb / 2^32) - (pa.pb + ma*mb), clamped to +-2^55
    // ------------------------------------------------------------------
    logic signed [TRW-1:0] traw  [3];
    logic signed [T_W-1:0] t_reg [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            traw[k] = $signed(TRW'(eprod_reg[k] >> FRAC_SH)) - TRW'(acc_f_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (traw[k] > TRW'(T_LIMIT))
                    t_reg[k] <= T_LIMIT;
                else if (traw[k] < -TRW'(T_LIMIT))
                    t_reg[k] <= -T_LIMIT;
                else
                    t_reg[k] <= T_W'(traw[k]);
            end
        end
    end

    // ------------------------------------------------------------------
    // u = t + 2 ma mb, s = (ma+mb)^2 + 2t, magnitudes and sign
    // ------------------------------------------------------------------
    logic signed [U_W-1:0] u_v  [3];
    logic signed [U_W-1:0] s_v  [3];
    logic [T_W-1:0]        tabs [3];
    logic [U_W-1:0]        uabs [3];
    logic [MAG_W-1:0]      mt_reg [3];
    logic [MAG_W-1:0]      mu_reg [3];
    logic [D_W-1:0]        dd0_reg [3];
    logic                  z0_reg  [3];
    logic                  n0_reg  [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            u_v[k]  = U_W'(t_reg[k]) + U_W'({mprod[k], 1'b0});
            s_v[k]  = U_W'(msum[k]) + {t_reg[k], 1'b0};
            tabs[k] = t_reg[k][T_W-1] ? -t_reg[k] : t_reg[k];
            uabs[k] = u_v[k][U_W-1] ? -u_v[k] : u_v[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                mt_reg[k]  <= tabs[k][MAG_W-1:0];
                mu_reg[k]  <= uabs[k][MAG_W-1:0];
                dd0_reg[k] <= s_v[k][D_W-1:0];
                // nonpositive denominator or vanishing factor: term is zero
                z0_reg[k]  <= s_v[k][U_W-1] || (s_v[k] == '0)
                            || (t_reg[k] == '0) || (u_v[k] == '0);
                n0_reg[k]  <= t_reg[k][T_W-1] ^ u_v[k][U_W-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // |t|*|u| as four half-width partial products, then summed
    // ------------------------------------------------------------------
    logic [MAG_W-1:0] np_reg  [3][4];
    logic [D_W-1:0]   dd1_reg [3];
    logic             z1_reg  [3];
    logic             n1_reg  [3];

    logic [N_W-1:0]   dn_reg   [3][ND+1];
    logic [D_W-1:0]   drem_reg [3][ND+1];
    logic [QUO_W-1:0] dq_reg   [3][ND+1];
    logic             dov_reg  [3][ND+1];
    logic [D_W-1:0]   dd_reg   [3][ND+1];
    logic             dz_reg   [3][ND+1];
    logic             dneg_reg [3][ND+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                np_reg[k][0] <= mt_reg[k][HALF_W-1:0]     * mu_reg[k][HALF_W-1:0];
                np_reg[k][1] <= mt_reg[k][HALF_W-1:0]     * mu_reg[k][MAG_W-1:HALF_W];
                np_reg[k][2] <= mt_reg[k][MAG_W-1:HALF_W] * mu_reg[k][HALF_W-1:0];
                np_reg[k][3] <= mt_reg[k][MAG_W-1:HALF_W] * mu_reg[k][MAG_W-1:HALF_W];
                dd1_reg[k]   <= dd0_reg[k];
                z1_reg[k]    <= z0_reg[k];
                n1_reg[k]    <= n0_reg[k];

                dn_reg[k][0]   <= (N_W'(np_reg[k][3]) << MAG_W)
                                + ((N_W'(np_reg[k][1]) + N_W'(np_reg[k][2])) << HALF_W)
                                + N_W'(np_reg[k][0]);
                drem_reg[k][0] <= '0;
                dq_reg[k][0]   <= '0;
                dov_reg[k][0]  <= 1'b0;
                dd_reg[k][0]   <= dd1_reg[k];
                dz_reg[k][0]   <= z1_reg[k];
                dneg_reg[k][0] <= n1_reg[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Restoring divider, one quotient bit per stage, sticky overflow
    // once the quotient passes its kept width
    // ------------------------------------------------------------------
    for (genvar i = 0; i < ND; i++)
    begin : g_div
        logic [D_W:0] r2 [3];
        logic [D_W:0] df [3];

        always_comb
        begin
            for (int k = 0; k < 3; k++)
            begin
                r2[k] = {drem_reg[k][i], dn_reg[k][i][N_W-1]};
                df[k] = r2[k] - {1'b0, dd_reg[k][i]};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    dn_reg[k][i+1]   <= {dn_reg[k][i][N_W-2:0], 1'b0};
                    drem_reg[k][i+1] <= (r2[k] >= {1'b0, dd_reg[k][i]}) ? df[k][D_W-1:0]
                                                                        : r2[k][D_W-1:0];
                    dq_reg[k][i+1]   <= {dq_reg[k][i][QUO_W-2:0],
                                         (r2[k] >= {1'b0, dd_reg[k][i]})};
                    dov_reg[k][i+1]  <= dov_reg[k][i] | dq_reg[k][i][QUO_W-1];
                    dd_reg[k][i+1]   <= dd_reg[k][i];
                    dz_reg[k][i+1]   <= dz_reg[k][i];
                    dneg_reg[k][i+1] <= dneg_reg[k][i];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Saturate, sign and sum the three pair terms
    // ------------------------------------------------------------------
    logic [QUO_W-1:0]        qs   [3];
    logic signed [SUM_W-1:0] term [3];
    logic signed [SUM_W-1:0] sum_v;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            qs[k]   = (dov_reg[k][ND] || (dq_reg[k][ND] > TERM_LIMIT)) ? TERM_LIMIT
                                                                         : dq_reg[k][ND];
            term[k] = dz_reg[k][ND] ? '0
                    : (dneg_reg[k][ND] ? -SUM_W'(qs[k]) : SUM_W'(qs[k]));
        end
        sum_v = term[0] + term[1] + term[2];
    end

    logic [RAD_W-1:0] fx_reg    [RT_W+1];
    logic [RT_W:0]    frem_reg  [RT_W+1];
    logic [RT_W-1:0]  froot_reg [RT_W+1];
    logic             fneg_reg  [RT_W+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fx_reg[0]    <= sum_v[SUM_W-1] ? '0 : RAD_W'(sum_v[SUM_W-2:0]);
            frem_reg[0]  <= '0;
            froot_reg[0] <= '0;
            fneg_reg[0]  <= sum_v[SUM_W-1];
        end
    end

    // ------------------------------------------------------------------
    // Final root, two radicand bits per stage
    // ------------------------------------------------------------------
    for (genvar j = 0; j < RT_W; j++)
    begin : g_fsq
        logic [RT_W+2:0] r4;
        logic [RT_W+2:0] tr;
        logic [RT_W+2:0] df;

        always_comb
        begin
            r4 = {frem_reg[j], fx_reg[j][RAD_W-1 -: 2]};
            tr = {1'b0, froot_reg[j], 2'b01};
            df = r4 - tr;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                fx_reg[j+1]    <= {fx_reg[j][RAD_W-3:0], 2'b00};
                frem_reg[j+1]  <= (r4 >= tr) ? df[RT_W:0] : r4[RT_W:0];
                froot_reg[j+1] <= {froot_reg[j][RT_W-2:0], (r4 >= tr)};
                fneg_reg[j+1]  <= fneg_reg[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output buffer
    // ------------------------------------------------------------------
    logic [Q3_W-1:0] q3_v;
    logic [Q3_W-1:0] fq_reg [2];
    logic            fn_reg [2];

    assign q3_v = (froot_reg[RT_W] > RT_W'(Q3_MAX)) ? Q3_MAX : froot_reg[RT_W][Q3_W-1:0];

    always_comb
    begin
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 2'd1;
            2'b01:   cnt_next = cnt_reg - 2'd1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fq_reg[wp_reg] <= q3_v;
            fn_reg[wp_reg] <= fneg_reg[RT_W];
        end
    end

    assign result.q3_value          = fq_reg[rp_reg];
    assign result.negative_radicand = fn_reg[rp_reg];

endmodule

`default_nettype wire

FILE: sv/tbi_checker.sv
`default_nettype none
`include "assert_macros.svh"

module tbi_checker (
    input wire                  clk,
    input wire                  rst_n,
    input wire                  in_ready,
    input wire                  out_valid,
    input wire                  out_ready,
    input wire [tbi_pkg::Q3_W-1:0] q3_value,
    input wire                  negative_radicand
);
    import tbi_pkg::*;

    `TBI_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
    `TBI_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(q3_value) && $stable(negative_radicand), "stalled result changed")
    `TBI_ASSERT_IMP(a_neg_zero, clk, rst_n, out_valid && negative_radicand, q3_value == '0, "flagged result is not zero")
    `TBI_ASSERT_IMP(a_stall_cause, clk, rst_n, !in_ready, out_valid && !out_ready, "input stalled without a waiting result")

endmodule

bind three_body_invariant_q3_top tbi_checker u_tbi_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_ready          (triplet.ready),
    .out_valid         (result.valid),
    .out_ready         (result.ready),
    .q3_value          (result.q3_value),
    .negative_radicand (result.negative_radicand)
);

`default_nettype wire

FILE: verif/three_body_invariant_q3_top_tb.sv
`timescale 1ns / 100ps
`default_nettype none

module three_body_invariant_q3_top_tb;
    import tbi_pkg::*;

    localparam int MB            = MOMENTUM_BITS_DEF;
    localparam int LATENCY       = 196;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int RANDOM_ITEMS  = 750;
    // index that decodes to no register; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'hA5;

    typedef logic signed [MB-1:0] mom_t;
    typedef mom_t triplet_t [9];
    typedef struct {
        logic [Q3_W-1:0] q3;
        logic            neg;
    } q3_result_t;

    // momentum flavors for the random stimulus
    typedef enum int { MOM_TINY, MOM_PHYS, MOM_FULL, MOM_EDGE } mom_kind_t;

    logic clk;
    logic rst_n;

    tbi_in_if #(.MOMENTUM_BITS(MB)) triplet_ch ();
    tbi_out_if                      result_ch ();
    tbi_cfg_if                      cfg_ch ();

    three_body_invariant_q3_top #(.MOMENTUM_BITS(MB)) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .triplet (triplet_ch),
        .result  (result_ch),
        .cfg     (cfg_ch)
    );

    // masses as the block should currently hold them
    logic [MASS_W-1:0] proton_mass_q;
    logic [MASS_W-1:0] lambda_mass_q;

    q3_result_t q3_pending [$];
    int         fail_count;
    int         cycle_count;
    int         hold_left;      // long receiver hold-off, counted down by the receiver
    int         burst_left;     // sender burst bookkeeping
    bit         sender_gaps;    // zero -> back-to-back requests

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------

    // floor(sqrt(r)) for the energy, 48-bit root
    function automatic logic [47:0] energy_root(logic [127:0] r);
        logic [127:0] res;
        logic [127:0] c;
        res = '0;
        for (int b = 47; b >= 0; b--)
        begin
            c = res | (128'd1 << b);
            if (c * c <= r)
                res = c;
        end
        return res[47:0];
    endfunction

    // -q.q of one pair, with clamps as the datapath applies them
    function automatic logic signed [63:0] pair_q2(triplet_t tr, int a, int b,
                                                   logic signed [127:0] ea,
                                                   logic signed [127:0] eb,
                                                   logic signed [127:0] ma,
                                                   logic signed [127:0] mb);
        logic signed [127:0] acc, full, t, u, s, lim, mt, mu, quo, cap;
        logic signed [127:0] sa, sb;
        lim = 1;
        lim = lim <<< 55;
        cap = 1;
        cap = cap <<< 60;
        acc = ma * mb;
        for (int i = 0; i < 3; i++)
        begin
            sa = tr[3*a+i];
            sb = tr[3*b+i];
            acc = acc + sa * sb;
        end
        full = ea * eb - (acc <<< 32);
        t = full >>> 32;
        if (t > lim)
            t = lim;
        if (t < -lim)
            t = -lim;
        u = t + 2 * ma * mb;
        s = (ma + mb) * (ma + mb) + 2 * t;
        if (s <= 0 || t == 0 || u == 0)
            return 64'sd0;
        mt = (t < 0) ? -t : t;
        mu = (u < 0) ? -u : u;
        quo = (mt * mu) / s;
        if (quo > cap)
            quo = cap;
        return ((t < 0) != (u < 0)) ? -quo[63:0] : quo[63:0];
    endfunction

    function automatic q3_result_t predict_q3(triplet_t tr);
        logic signed [127:0] en [3];
        logic signed [127:0] ms [3];
        logic signed [127:0] p2, sv;
        logic signed [63:0]  total;
        logic [63:0]         root, c;
        q3_result_t          r;
        ms[0] = $signed({106'd0, lambda_mass_q});
        ms[1] = $signed({106'd0, proton_mass_q});
        ms[2] = ms[1];
        for (int k = 0; k < 3; k++)
        begin
            p2 = 0;
            for (int i = 0; i < 3; i++)
            begin
                sv = tr[3*k+i];
                p2 = p2 + sv * sv;
            end
            en[k] = $signed({80'd0, energy_root((p2 + ms[k] * ms[k]) <<< 32)});
        end
        total = pair_q2(tr, 0, 1, en[0], en[1], ms[0], ms[1])
              + pair_q2(tr, 1, 2, en[1], en[2], ms[1], ms[2])
              + pair_q2(tr, 2, 0, en[2], en[0], ms[2], ms[0]);
        if (total < 0)
        begin
            r.q3  = '0;
            r.neg = 1'b1;
        end
        else
        begin
            root = '0;
            for (int b = 31; b >= 0; b--)
            begin
                c = root | (64'd1 << b);
                if (c * c <= total)
                    root = c;
            end
            r.q3  = (root > Q3_MAX) ? Q3_MAX : root[Q3_W-1:0];
            r.neg = 1'b0;
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------

    // one triplet request; valid stays up for the caller's next request
    task automatic send_triplet(triplet_t tr);
        @(negedge clk);
        triplet_ch.valid            <= 1'b1;
        triplet_ch.lambda_px        <= tr[0];
        triplet_ch.lambda_py        <= tr[1];
        triplet_ch.lambda_pz        <= tr[2];
        triplet_ch.first_proton_px  <= tr[3];
        triplet_ch.first_proton_py  <= tr[4];
        triplet_ch.first_proton_pz  <= tr[5];
        triplet_ch.second_proton_px <= tr[6];
        triplet_ch.second_proton_py <= tr[7];
        triplet_ch.second_proton_pz <= tr[8];
        do
            @(posedge clk);
        while (!triplet_ch.ready);
        q3_pending.insert(q3_pending.size(), predict_q3(tr));
    endtask

    task automatic idle_sender(int cycles);
        @(negedge clk);
        triplet_ch.valid <= 1'b0;
        repeat (cycles)
            @(negedge clk);
    endtask

    // burst/gap shaping around each request
    task automatic send_paced(triplet_t tr);
        if (sender_gaps && burst_left == 0)
        begin
            idle_sender($urandom_range(0, 8));
            burst_left = $urandom_range(1, 40);
        end
        send_triplet(tr);
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic wait_drained();
        idle_sender(0);
        wait (q3_pending.size() == 0);
        repeat (LATENCY + 20)
            @(negedge clk);
    endtask

    // register write; only called with the pipeline empty
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        if (idx == REG_PROTON_MASS)
            proton_mass_q = data[MASS_W-1:0];
        else if (idx == REG_LAMBDA_MASS)
            lambda_mass_q = data[MASS_W-1:0];
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic mom_t rand_mom(mom_kind_t kind);
        case (kind)
            MOM_TINY: return mom_t'($urandom_range(0, 2000) - 1000);
            MOM_PHYS: return mom_t'($urandom_range(0, 4000000) - 2000000);
            MOM_EDGE: return ($urandom_range(0, 1) != 0) ? mom_t'({1'b0, {(MB-1){1'b1}}})
                                                       : mom_t'({1'b1, {(MB-1){1'b0}}});
            default:  return mom_t'($urandom);
        endcase
    endfunction

    function automatic triplet_t rand_triplet();
        triplet_t  tr;
        mom_kind_t kind;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            kind = MOM_PHYS;
        else if (pick < 75)
            kind = MOM_TINY;
        else if (pick < 95)
            kind = MOM_FULL;
        else
            kind = MOM_EDGE;
        for (int i = 0; i < 9; i++)
            tr[i] = rand_mom(kind);
        // sometimes clone a particle, where pair energies nearly cancel
        if ($urandom_range(0, 9) == 0)
            for (int i = 0; i < 3; i++)
                tr[3 + i] = tr[6 + i];
        return tr;
    endfunction

    function automatic triplet_t fill_triplet(mom_t v);
        triplet_t tr;
        for (int i = 0; i < 9; i++)
            tr[i] = v;
        return tr;
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // default masses: zeros, extremes, identical particles, one field at a time
    task automatic test_default_masses();
        triplet_t tr;
        send_triplet(fill_triplet('0));
        send_triplet(fill_triplet({1'b0, {(MB-1){1'b1}}}));
        send_triplet(fill_triplet({1'b1, {(MB-1){1'b0}}}));
        send_triplet(fill_triplet(mom_t'(-1)));
        send_triplet(fill_triplet(mom_t'(123456)));
        // head-on extremes: largest t, saturated Q3
        tr = fill_triplet({1'b0, {(MB-1){1'b1}}});
        for (int i = 3; i < 6; i++)
            tr[i] = {1'b1, {(MB-1){1'b0}}};
        send_triplet(tr);
        // one field nonzero at a time, both extremes
        for (int i = 0; i < 9; i++)
        begin
            tr = fill_triplet('0);
            tr[i] = (i % 2 != 0) ? {1'b1, {(MB-1){1'b0}}} : {1'b0, {(MB-1){1'b1}}};
            send_triplet(tr);
        end
        wait_drained();
    endtask

    // mass registers at their extremes, plus ignored and masked writes
    task automatic test_mass_extremes();
        triplet_t tr;
        logic [CFG_DATA_W-1:0] setting [4][2];
        setting[0] = '{32'd0, 32'd0};
        setting[1] = '{32'hFFFF_FFFF, 32'hFFC0_0000};  // only low bits kept
        setting[2] = '{32'd0, 32'h003F_FFFF};
        setting[3] = '{32'd1, 32'd2};
        for (int k = 0; k < 4; k++)
        begin
            write_reg(REG_PROTON_MASS, setting[k][0]);
            write_reg(REG_LAMBDA_MASS, setting[k][1]);
            write_reg(REG_UNMAPPED, $urandom);
            send_triplet(fill_triplet('0));
            tr = fill_triplet(mom_t'(-5000));
            tr[4] = mom_t'(7000);
            send_triplet(tr);
            for (int i = 0; i < 20; i++)
                send_paced(rand_triplet());
            wait_drained();
        end
    endtask

    task automatic test_random_stream();
        int phase_len;
        int sent;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 3))
                0: write_reg(REG_PROTON_MASS, CFG_DATA_W'(PROTON_MASS_RST));
                1: write_reg(REG_PROTON_MASS, $urandom);
                2: write_reg(REG_LAMBDA_MASS, $urandom_range(0, 4194303));
                default: write_reg(REG_LAMBDA_MASS, CFG_DATA_W'(LAMBDA_MASS_RST));
            endcase
            sender_gaps = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(100, 250);
            for (int i = 0; i < phase_len; i++)
                send_paced(rand_triplet());
            sent += phase_len;
            wait_drained();
        end
    endtask

    // receiver holds off for a long stretch; sender keeps pushing until stalled
    task automatic test_output_stall();
        sender_gaps = 1'b0;
        hold_left = 4 * LATENCY;
        for (int i = 0; i < 400; i++)
            send_paced(rand_triplet());
        wait_drained();
    endtask

    // ---------------------------------------------------------------
    // Receiver: random stalls in phases, plus the long hold-off
    // ---------------------------------------------------------------
    initial
    begin : receiver
        bit stall_phase;
        int phase_left;
        stall_phase = 1'b0;
        phase_left  = 0;
        forever
        begin
            @(negedge clk);
            if (phase_left == 0)
            begin
                stall_phase = ($urandom_range(0, 2) != 0);
                phase_left  = $urandom_range(20, 300);
            end
            phase_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (stall_phase)
                result_ch.ready <= ($urandom_range(0, 3) != 0);
            else
                result_ch.ready <= 1'b1;
        end
    end

    // result checker, compares in order against predictions
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (q3_pending.size() == 0)
            begin
                $error("unexpected result q3_value=%0d negative_radicand=%0b",
                       result_ch.q3_value, result_ch.negative_radicand);
                fail_count++;
            end
            else
            begin
                q3_result_t want;
                want = q3_pending.pop_front();
                if (result_ch.q3_value !== want.q3)
                begin
                    $error("q3_value: expected %0d, got %0d", want.q3, result_ch.q3_value);
                    fail_count++;
                end
                if (result_ch.negative_radicand !== want.neg)
                begin
                    $error("negative_radicand: expected %0b, got %0b",
                           want.neg, result_ch.negative_radicand);
                    fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        clk              = 1'b0;
        rst_n            = 1'b0;
        fail_count       = 0;
        cycle_count      = 0;
        hold_left        = 0;
        burst_left       = 0;
        sender_gaps      = 1'b1;
        proton_mass_q    = PROTON_MASS_RST;
        lambda_mass_q    = LAMBDA_MASS_RST;
        triplet_ch.valid = 1'b0;
        triplet_ch.lambda_px        = '0;
        triplet_ch.lambda_py        = '0;
        triplet_ch.lambda_pz        = '0;
        triplet_ch.first_proton_px  = '0;
        triplet_ch.first_proton_py  = '0;
        triplet_ch.first_proton_pz  = '0;
        triplet_ch.second_proton_px = '0;
        triplet_ch.second_proton_py = '0;
        triplet_ch.second_proton_pz = '0;
        result_ch.ready  = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.index     = '0;
        cfg_ch.data      = '0;
        repeat (11)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_default_masses();
        test_mass_extremes();
        test_random_stream();
        test_output_stall();

        if (fail_count == 0 && q3_pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
